### rtl/lrtf_pkg.sv
// ----------------------------------------------------------------------------
// lrtf_pkg
// Shared types and constants of the longest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package lrtf_pkg;

	localparam int FIELD_W      = 16;
	localparam int TIME_W       = 22;
	localparam int MAX_PROC_DEF = 64;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [FIELD_W-1:0] proc_id;
		logic [FIELD_W-1:0] arrival_time;
		logic [FIELD_W-1:0] burst_length;
	} req_t;

	typedef struct packed {
		logic              table_full;
		logic              idle;
		logic [FIELD_W-1:0] ran_id;
		logic              finished;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              all_done;
	} rsp_t;

	// one process table entry, as stored in memory
	typedef struct packed {
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] arrival;
		logic [FIELD_W-1:0] remaining;
		logic [FIELD_W-1:0] burst;
	} entry_t;

	// current pick of the scan
	typedef struct packed {
		logic   have;
		entry_t ent;
	} best_t;

endpackage

### rtl/lrtf_entry_mem.sv
// ----------------------------------------------------------------------------
// lrtf_entry_mem
// Process table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrtf_entry_mem
	import lrtf_pkg::*;
#(
	parameter int DEPTH = MAX_PROC_DEF,
	parameter int IDX_W = $clog2(MAX_PROC_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/lrtf_best_sel.sv
// ----------------------------------------------------------------------------
// lrtf_best_sel
// Running selection over the scanned entries: keeps the ready entry with the
// most remaining work, lower id on a tie, first seen on a full tie.
// ----------------------------------------------------------------------------
module lrtf_best_sel
	import lrtf_pkg::*;
#(
	parameter int IDX_W = $clog2(MAX_PROC_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              vld,
	input  entry_t            ent,
	input  logic [IDX_W-1:0]  idx,
	input  logic [TIME_W-1:0] now,
	output best_t             best,
	output logic [IDX_W-1:0]  best_idx
);

	logic             have_q;
	entry_t           ent_q;
	logic [IDX_W-1:0] best_idx_q;

	logic eligible;
	logic better;
	logic take;

	assign best     = {have_q, ent_q};
	assign best_idx = best_idx_q;

	// ready and with work left
	assign eligible = vld && (ent.remaining != '0) &&
		({{(TIME_W-FIELD_W){1'b0}}, ent.arrival} <= now);

	assign better = !have_q || (ent.remaining > ent_q.remaining) ||
		((ent.remaining == ent_q.remaining) && (ent.id < ent_q.id));

	assign take = eligible && better;

	// have flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (clear) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	// held entry
	always_ff @(posedge clk) begin
		if (take && !clear) begin
			ent_q      <= ent;
			best_idx_q <= idx;
		end
	end

endmodule

### rtl/lrtf_process_scheduler_unit.sv
// ----------------------------------------------------------------------------
// lrtf_process_scheduler_unit
// Preemptive longest-remaining-time-first scheduler over a table of processes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot stall it. A load's result appears the next cycle. A tick reads
// the table one entry per cycle through the single read port of the entry
// memory, then passes through the drain, write-back and output states; an
// empty table skips the read and drain states. busy drops in the cycle the
// result is shown, so the next request can be taken then.
// all_done comes from a count of unfinished entries, not from a scan.
// ----------------------------------------------------------------------------
module lrtf_process_scheduler_unit
	import lrtf_pkg::*;
#(
	parameter int MAX_PROCESSES = MAX_PROC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t result
);

	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCESSES);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_UPD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   entry_count_q;
	logic [CNT_W-1:0]   active_q;
	logic [TIME_W-1:0]  time_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               fin_q;
	logic [TIME_W-1:0]  tat_q;
	logic               done_q;
	rsp_t               result_q;

	logic               accept;
	logic               full;
	logic [CNT_W-1:0]   load_active;
	logic               last_issue;
	logic [TIME_W-1:0]  time_next;
	logic [TIME_W-1:0]  arr_ext;
	logic [TIME_W-1:0]  bur_ext;
	logic [TIME_W-1:0]  wait_val;
	logic               best_fin;
	rsp_t               load_rsp;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	entry_t             mem_rdata;
	best_t              best;
	logic [IDX_W-1:0]   best_idx;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign full        = (entry_count_q == CNT_FULL);
	assign load_active = active_q + CNT_W'(!full && (req.burst_length != '0));
	assign last_issue  = (CNT_W'(scan_idx_q) == entry_count_q - CNT_W'(1));
	assign time_next   = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
	assign arr_ext     = {{(TIME_W-FIELD_W){1'b0}}, best.ent.arrival};
	assign bur_ext     = {{(TIME_W-FIELD_W){1'b0}}, best.ent.burst};
	assign wait_val    = (tat_q > bur_ext) ? tat_q - bur_ext : '0;
	assign best_fin    = (best.ent.remaining == FIELD_W'(1));

	// load result: only table_full and all_done can be set
	always_comb begin
		load_rsp            = '0;
		load_rsp.table_full = full;
		load_rsp.all_done   = (load_active == '0);
	end

	// memory write: append on load, decremented entry on write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = best_idx;
		mem_wdata = best.ent;
		mem_wdata.remaining = best.ent.remaining - FIELD_W'(1);
		if (state_q == ST_IDLE) begin
			mem_we    = accept && (req.kind == KIND_LOAD) && !full;
			mem_waddr = entry_count_q[IDX_W-1:0];
			mem_wdata.id        = req.proc_id;
			mem_wdata.arrival   = req.arrival_time;
			mem_wdata.remaining = req.burst_length;
			mem_wdata.burst     = req.burst_length;
		end else if (state_q == ST_UPD) begin
			mem_we = best.have;
		end
	end

	lrtf_entry_mem #(
		.DEPTH (MAX_PROCESSES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (scan_idx_q),
		.rdata (mem_rdata)
	);

	lrtf_best_sel #(
		.IDX_W (IDX_W)
	) u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.vld      (rd_vld_s1),
		.ent      (mem_rdata),
		.idx      (idx_s1),
		.now      (time_q),
		.best     (best),
		.best_idx (best_idx)
	);

	// control: state, counters, time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			active_q      <= '0;
			time_q        <= '0;
			scan_idx_q    <= '0;
			rd_vld_s1     <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					scan_idx_q <= '0;
					if (accept) begin
						if (req.kind == KIND_LOAD) begin
							done_q   <= 1'b1;
							active_q <= load_active;
							if (!full) begin
								entry_count_q <= entry_count_q + CNT_W'(1);
							end
						end else if (entry_count_q == '0) begin
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					time_q <= time_next;
					if (best.have && best_fin) begin
						active_q <= active_q - CNT_W'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (state_q == ST_UPD) begin
			fin_q <= best.have && best_fin;
			tat_q <= (time_next > arr_ext) ? time_next - arr_ext : '0;
		end
		if (state_q == ST_IDLE && accept && req.kind == KIND_LOAD) begin
			result_q <= load_rsp;
		end else if (state_q == ST_OUT) begin
			result_q.table_full      <= 1'b0;
			result_q.idle            <= !best.have;
			result_q.ran_id          <= best.have ? best.ent.id : '0;
			result_q.finished        <= fin_q;
			result_q.completion_time <= fin_q ? time_q : '0;
			result_q.turnaround      <= fin_q ? tat_q : '0;
			result_q.waiting         <= fin_q ? wait_val : '0;
			result_q.all_done        <= (active_q == '0);
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_FULL)
		else $error("entry count beyond table size");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= entry_count_q)
		else $error("unfinished count exceeds entry count");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> done)
		else $error("tick result not shown after write-back");

	a_idle_no_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.idle |-> !result.finished && result.ran_id == '0)
		else $error("idle tick reports a run");

endmodule

### tb/tb_lrtf_process_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_lrtf_process_scheduler_unit
// Self-checking bench for the longest-remaining-time-first scheduler: loads
// and ticks go in through a queued driver, and every result is compared with
// a scheduler model kept in the bench.
// ----------------------------------------------------------------------------
module tb_lrtf_process_scheduler_unit;
	import lrtf_pkg::*;

	localparam int MAX_PROCS  = MAX_PROC_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_REQS = 1400;

	typedef struct {
		req_t r;
		bit   wait_drain;
	} queued_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t result;

	queued_req_t pending_reqs[$];
	rsp_t        expected_rsps[$];

	// scheduler model state
	logic [FIELD_W-1:0] proc_ids[MAX_PROCS];
	logic [FIELD_W-1:0] proc_arrivals[MAX_PROCS];
	logic [FIELD_W-1:0] proc_left[MAX_PROCS];
	logic [FIELD_W-1:0] proc_bursts[MAX_PROCS];
	int                 loaded_count = 0;
	logic [TIME_W-1:0]  sim_now = '0;

	int error_count = 0;
	int sent_count = 0;
	int rsp_count = 0;
	int idle_cycles = 0;
	int gen_loads = 0;
	int gen_ticks = 0;

	lrtf_process_scheduler_unit #(.MAX_PROCESSES(MAX_PROCS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model one request: update the table and time, return the expected result
	function automatic rsp_t schedule_step(input req_t r);
		rsp_t o;
		logic found;
		int pick;
		int i;
		logic [TIME_W-1:0] tat;
		logic [TIME_W-1:0] wt;
		o = '0;
		found = 1'b0;
		pick = 0;
		if (r.kind == KIND_LOAD) begin
			if (loaded_count >= MAX_PROCS) begin
				o.table_full = 1'b1;
			end else begin
				proc_ids[loaded_count] = r.proc_id;
				proc_arrivals[loaded_count] = r.arrival_time;
				proc_left[loaded_count] = r.burst_length;
				proc_bursts[loaded_count] = r.burst_length;
				loaded_count++;
			end
		end else begin
			// most work left wins, lower id on a tie, earlier entry on a full tie
			for (i = 0; i < loaded_count; i++) begin
				if (proc_left[i] != 0 && TIME_W'(proc_arrivals[i]) <= sim_now) begin
					if (!found) begin
						found = 1'b1;
						pick = i;
					end else if (proc_left[i] > proc_left[pick]) begin
						pick = i;
					end else if (proc_left[i] == proc_left[pick] &&
							proc_ids[i] < proc_ids[pick]) begin
						pick = i;
					end
				end
			end
			if (sim_now < TIME_MAX)
				sim_now++;
			if (!found) begin
				o.idle = 1'b1;
			end else begin
				proc_left[pick]--;
				o.ran_id = proc_ids[pick];
				if (proc_left[pick] == 0) begin
					tat = (sim_now > TIME_W'(proc_arrivals[pick])) ?
						sim_now - TIME_W'(proc_arrivals[pick]) : '0;
					wt = (tat > TIME_W'(proc_bursts[pick])) ?
						tat - TIME_W'(proc_bursts[pick]) : '0;
					o.finished = 1'b1;
					o.completion_time = sim_now;
					o.turnaround = tat;
					o.waiting = wt;
				end
			end
		end
		o.all_done = 1'b1;
		for (i = 0; i < loaded_count; i++)
			if (proc_left[i] != 0)
				o.all_done = 1'b0;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
			rsp_count, what, got, want);
		error_count++;
	endtask

	task automatic add_load(input logic [FIELD_W-1:0] id, input logic [FIELD_W-1:0] arr,
			input logic [FIELD_W-1:0] bur);
		queued_req_t q;
		q.r.kind = KIND_LOAD;
		q.r.proc_id = id;
		q.r.arrival_time = arr;
		q.r.burst_length = bur;
		q.wait_drain = 1'b0;
		pending_reqs.push_back(q);
		gen_loads++;
	endtask

	// tick fields other than kind carry junk, the block must ignore them
	task automatic add_tick();
		queued_req_t q;
		q.r.kind = KIND_TICK;
		q.r.proc_id = FIELD_W'($urandom);
		q.r.arrival_time = FIELD_W'($urandom);
		q.r.burst_length = FIELD_W'($urandom);
		q.wait_drain = 1'b0;
		pending_reqs.push_back(q);
		gen_ticks++;
	endtask

	// driver: present the head of the queue, hold it until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_rsps.push_back(schedule_step(req));
				pending_reqs.delete(0);
				sent_count++;
			end
			if (!start || !busy) begin
				if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].wait_drain && expected_rsps.size() != 0) &&
						((sent_count >= 500 && sent_count < 800) ||
						$urandom_range(0, 99) >= 19)) begin
					start <= 1'b1;
					req <= pending_reqs[0].r;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("result with no request outstanding, ran_id",
					32'(result.ran_id), '0);
			end else begin
				want = expected_rsps.pop_front();
				if (result.table_full !== want.table_full)
					report_mismatch("table_full", 32'(result.table_full),
						32'(want.table_full));
				if (result.idle !== want.idle)
					report_mismatch("idle", 32'(result.idle), 32'(want.idle));
				if (result.ran_id !== want.ran_id)
					report_mismatch("ran_id", 32'(result.ran_id), 32'(want.ran_id));
				if (result.finished !== want.finished)
					report_mismatch("finished", 32'(result.finished),
						32'(want.finished));
				if (result.completion_time !== want.completion_time)
					report_mismatch("completion_time", 32'(result.completion_time),
						32'(want.completion_time));
				if (result.turnaround !== want.turnaround)
					report_mismatch("turnaround", 32'(result.turnaround),
						32'(want.turnaround));
				if (result.waiting !== want.waiting)
					report_mismatch("waiting", 32'(result.waiting), 32'(want.waiting));
				if (result.all_done !== want.all_done)
					report_mismatch("all_done", 32'(result.all_done),
						32'(want.all_done));
			end
			rsp_count++;
		end
	end

	// watchdog: no request and no result for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no progress for %0d cycles", STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int sel;
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] arr;
		logic [FIELD_W-1:0] bur;

		// directed: empty table, zero burst, id extremes, ties, late load
		add_tick();
		add_load(16'd5, 16'd0, 16'd0);
		add_tick();
		add_load(16'hFFFF, 16'd0, 16'd3);
		add_load(16'd0, 16'd0, 16'd3);
		add_load(16'd7, 16'd5, 16'd4);
		add_load(16'd9, 16'd0, 16'd2);
		add_load(16'd9, 16'd0, 16'd2);
		repeat (10) add_tick();
		add_load(16'd3, 16'd0, 16'd1);
		repeat (6) add_tick();

		// random: mostly ticks, loads sprinkled in with short bursts
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (gen_loads < MAX_PROCS - 2 && $urandom_range(0, 99) < 5) begin
				id = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom) :
					FIELD_W'($urandom_range(0, 15));
				if ($urandom_range(0, 3) == 0)
					arr = FIELD_W'($urandom_range(0, gen_ticks));
				else
					arr = FIELD_W'(gen_ticks + $urandom_range(0, 30));
				sel = $urandom_range(0, 9);
				if (sel == 0)
					bur = '0;
				else if (sel < 8)
					bur = FIELD_W'($urandom_range(1, 12));
				else
					bur = FIELD_W'($urandom_range(13, 80));
				add_load(id, arr, bur);
			end else begin
				add_tick();
			end
			// hold the sender until everything outstanding has come back
			if (n % 300 == 299)
				pending_reqs[$].wait_drain = 1'b1;
		end

		// fill the table, all-ones entry included, then loads into a full table
		add_load(16'hFFFF, 16'hFFFF, 16'hFFFF);
		while (gen_loads < MAX_PROCS)
			add_load(FIELD_W'($urandom), FIELD_W'(gen_ticks),
				FIELD_W'($urandom_range(1, 5)));
		repeat (4) add_load(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
		repeat (20) add_tick();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
rtl/lrtf_pkg.sv
rtl/lrtf_entry_mem.sv
rtl/lrtf_best_sel.sv
rtl/lrtf_process_scheduler_unit.sv
tb/tb_lrtf_process_scheduler_unit.sv
